/* hw/rtl/text_command_line_decoder_assert.svh */
// Assertion macros shared by the command line decoder RTL.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef TEXT_COMMAND_LINE_DECODER_ASSERT_SVH
`define TEXT_COMMAND_LINE_DECODER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TCLD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TCLD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/tcld_pkg.sv */
// Types, codes and character helpers of the text command line decoder.
// No dependencies; used by tcld_parser and text_command_line_decoder.
package tcld_pkg;

	localparam int MAX_LINE_DEF = 64;
	localparam int CHANNELS_DEF = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ALL   = 8'hFF;

	typedef enum logic [2:0] {
		K_SET  = 3'd0,
		K_EN   = 3'd1,
		K_DIS  = 3'd2,
		K_RST  = 3'd3,
		K_GET  = 3'd4,
		K_NONE = 3'd7
	} kind_t;

	typedef enum logic [7:0] {
		PH_START = 8'b0000_0001,
		PH_KW1   = 8'b0000_0010,
		PH_KW2   = 8'b0000_0100,
		PH_ARG1  = 8'b0000_1000,
		PH_NUM1  = 8'b0001_0000,
		PH_ARG2  = 8'b0010_0000,
		PH_NUM2  = 8'b0100_0000,
		PH_STOP  = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic mv;
		logic ch;
		logic dig;
		logic neg;
	} flags_t;

	typedef struct packed {
		phase_t      phase;
		kind_t       kind;
		logic [7:0]  ch_acc;
		logic [15:0] mv_acc;
		flags_t      flags;
	} parse_state_t;

	typedef struct packed {
		kind_t       command_kind;
		logic [7:0]  channel;
		logic [15:0] millivolts;
	} result_t;

	typedef struct packed {
		logic         emit;
		result_t      result;
		parse_state_t next_state;
	} step_out_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_eol(input logic [7:0] c);
		return (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
	endfunction

	function automatic parse_state_t cleared_state();
		parse_state_t s;
		s.phase  = PH_START;
		s.kind   = K_NONE;
		s.ch_acc = '0;
		s.mv_acc = '0;
		s.flags  = '0;
		return s;
	endfunction

endpackage

/* hw/rtl/tcld_parser.sv */
// One parser step of the command line decoder: next parser state for one
// byte, and the decoded command when the byte ends a line. Uses tcld_pkg.
module tcld_parser #(
	parameter int CHANNELS = tcld_pkg::CHANNELS_DEF
) (
	input  logic [7:0]            rx_byte,
	input  tcld_pkg::parse_state_t state,
	input  logic                  line_empty,
	input  logic                  line_room,
	output tcld_pkg::step_out_t   step
);
	import tcld_pkg::*;

	function automatic logic [7:0] kw_second(input kind_t k);
		logic [7:0] r;
		case (k)
			K_SET:   r = "E";
			K_EN:    r = "N";
			K_DIS:   r = "I";
			K_RST:   r = "S";
			K_GET:   r = "E";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_third(input kind_t k);
		logic [7:0] r;
		case (k)
			K_SET:   r = "T";
			K_DIS:   r = "S";
			K_RST:   r = "T";
			K_GET:   r = "T";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic parse_state_t fail_line(input parse_state_t st);
		parse_state_t nx;
		nx = st;
		nx.kind = (st.kind == K_RST) ? K_RST : K_NONE;
		nx.phase = PH_STOP;
		return nx;
	endfunction

	function automatic parse_state_t add_digit(input parse_state_t st, input logic [7:0] c,
			input logic first);
		parse_state_t nx;
		logic [7:0] d;
		nx = st;
		d = c - 8'h30;
		// Multiply by ten as two shifts and an add; wraps to the field width.
		if (first) begin
			nx.ch_acc = {st.ch_acc[4:0], 3'b000} + {st.ch_acc[6:0], 1'b0} + d;
		end else begin
			nx.mv_acc = {st.mv_acc[12:0], 3'b000} + {st.mv_acc[14:0], 1'b0} + {8'd0, d};
		end
		nx.flags.dig = 1'b1;
		return nx;
	endfunction

	function automatic parse_state_t arg_step(input parse_state_t st, input logic [7:0] c,
			input logic first);
		parse_state_t nx;
		nx = st;
		if (is_ws(c)) begin
			nx = st;
		end else if (c == CH_PLUS) begin
			nx.phase = first ? PH_NUM1 : PH_NUM2;
		end else if (c == CH_MINUS) begin
			nx.flags.neg = 1'b1;
			nx.phase = first ? PH_NUM1 : PH_NUM2;
		end else if (is_digit(c)) begin
			nx.phase = first ? PH_NUM1 : PH_NUM2;
			nx = add_digit(nx, c, first);
		end else begin
			nx = fail_line(st);
		end
		return nx;
	endfunction

	function automatic parse_state_t feed(input parse_state_t st, input logic [7:0] c);
		parse_state_t nx;
		logic [7:0] u;
		nx = st;
		u = upcase(c);
		unique case (st.phase)
			PH_START: begin
				if (!is_ws(c)) begin
					nx.phase = PH_KW1;
					case (u)
						"S":     nx.kind = K_SET;
						"E":     nx.kind = K_EN;
						"D":     nx.kind = K_DIS;
						"R":     nx.kind = K_RST;
						"G":     nx.kind = K_GET;
						default: begin
							nx.kind = K_NONE;
							nx.phase = PH_STOP;
						end
					endcase
				end
			end
			PH_KW1: begin
				if (u != kw_second(st.kind)) begin
					nx.kind = K_NONE;
					nx.phase = PH_STOP;
				end else begin
					nx.phase = (st.kind == K_EN) ? PH_ARG1 : PH_KW2;
				end
			end
			PH_KW2: begin
				if (u != kw_third(st.kind)) begin
					nx.kind = K_NONE;
					nx.phase = PH_STOP;
				end else begin
					nx.phase = (st.kind == K_GET) ? PH_STOP : PH_ARG1;
				end
			end
			PH_ARG1: nx = arg_step(st, c, 1'b1);
			PH_ARG2: nx = arg_step(st, c, 1'b0);
			PH_NUM1: begin
				if (is_digit(c)) begin
					nx = add_digit(st, c, 1'b1);
				end else if (!st.flags.dig) begin
					nx = fail_line(st);
				end else begin
					if (st.flags.neg) begin
						nx.ch_acc = 8'd0 - st.ch_acc;
					end
					nx.flags = '0;
					nx.flags.ch = 1'b1;
					if (st.kind != K_SET) begin
						nx.phase = PH_STOP;
					end else begin
						// The terminating byte is also the first byte seen by the
						// second argument.
						nx.phase = PH_ARG2;
						nx = arg_step(nx, c, 1'b0);
					end
				end
			end
			PH_NUM2: begin
				if (is_digit(c)) begin
					nx = add_digit(st, c, 1'b0);
				end else if (!st.flags.dig) begin
					nx = fail_line(st);
				end else begin
					if (st.flags.neg) begin
						nx.mv_acc = 16'd0 - st.mv_acc;
					end
					nx.flags = '0;
					nx.flags.ch = 1'b1;
					nx.flags.mv = 1'b1;
					nx.phase = PH_STOP;
				end
			end
			default: nx = st;
		endcase
		return nx;
	endfunction

	parse_state_t fed;
	parse_state_t fin;
	logic         in_range;
	logic [7:0]   rst_ch;

	assign fed = feed(state, rx_byte);
	assign fin = feed(state, CH_NUL);
	assign in_range = fin.flags.ch && (fin.ch_acc >= 8'd1) && (fin.ch_acc <= 8'(CHANNELS));
	assign rst_ch = fin.flags.ch ? fin.ch_acc : 8'd0;

	always_comb begin
		step.emit = 1'b0;
		step.result.command_kind = fin.kind;
		step.result.channel = '0;
		step.result.millivolts = '0;
		step.next_state = state;
		if (is_eol(rx_byte)) begin
			if (!line_empty) begin
				step.next_state = cleared_state();
				unique case (fin.kind)
					K_GET: step.emit = 1'b1;
					K_RST: begin
						step.emit = 1'b1;
						step.result.channel = (rst_ch != 8'd0) ? rst_ch - 8'd1 : CH_ALL;
					end
					K_EN, K_DIS: begin
						step.emit = in_range;
						step.result.channel = fin.ch_acc - 8'd1;
					end
					K_SET: begin
						step.emit = in_range && fin.flags.mv;
						step.result.channel = fin.ch_acc - 8'd1;
						step.result.millivolts = fin.mv_acc;
					end
					default: step.emit = 1'b0;
				endcase
			end
		end else if (line_room && state.phase != PH_STOP) begin
			step.next_state = fed;
			// A zero byte ends the text of the line.
			if (rx_byte == CH_NUL) begin
				step.next_state.phase = PH_STOP;
			end
		end
	end

endmodule

/* hw/rtl/text_command_line_decoder.sv */
// Text command line decoder: takes received bytes and emits decoded commands.
// Top level; depends on tcld_pkg, tcld_parser and the assertion macro header.
//
// Usage:
//   Bytes enter on the s_ channel, one per request, in s_tdata[7:0].
//   CR or LF ends a non-empty line; the line's command (SET ch mV, EN ch,
//   DIS ch, RST [ch], GET, keywords case-insensitive) leaves on the m_
//   channel if it parses, else nothing; GET and RST emit whatever follows.
//   Throughput is one byte per cycle while the receiver takes results: each
//   byte is held in an input register and one pass of the parser logic
//   updates the parser state and loads the result register.
//   The line-end byte passes through the input register, and the result of
//   its line is registered in the result register that drives m_tvalid.
//   When the receiver stalls with a result waiting, one more byte is taken
//   into the input register and s_tready then drops until the result goes.
//   Reset clears the parser, the line length and both valid flags; no
//   result is pending afterwards.
`include "text_command_line_decoder_assert.svh"

module text_command_line_decoder #(
	parameter int MAX_LINE = tcld_pkg::MAX_LINE_DEF,
	parameter int CHANNELS = tcld_pkg::CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [2:0] command_kind, [10:3] channel, [26:11] millivolts
);
	import tcld_pkg::*;

	localparam int LEN_W = $clog2(MAX_LINE);

	logic [7:0]   byte_s1;
	logic         valid_s1;
	result_t      result_s2;
	logic         out_valid_s2;
	parse_state_t state_q;
	logic [LEN_W-1:0] len_q;

	logic         advance;
	logic         line_room;
	step_out_t    step;

	assign advance = valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign line_room = len_q < LEN_W'(MAX_LINE - 1);

	tcld_parser #(
		.CHANNELS(CHANNELS)
	) u_parser (
		.rx_byte   (byte_s1),
		.state     (state_q),
		.line_empty(len_q == '0),
		.line_room (line_room),
		.step      (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cleared_state();
			len_q <= '0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= step.next_state;
				out_valid_s2 <= step.emit;
				if (is_eol(byte_s1)) begin
					len_q <= '0;
				end else if (line_room) begin
					len_q <= len_q + LEN_W'(1);
				end
			end else if (m_tready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.emit) begin
			result_s2 <= step.result;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata = {5'd0, result_s2.millivolts, result_s2.channel, result_s2.command_kind};

	`TCLD_ASSERT_SAME(a_mv_only_for_set,
		out_valid_s2 && result_s2.command_kind != K_SET, result_s2.millivolts == 16'd0,
		"millivolts nonzero on a command other than SET")
	`TCLD_ASSERT_SAME(a_en_dis_channel_range,
		out_valid_s2 && (result_s2.command_kind == K_EN || result_s2.command_kind == K_DIS),
		result_s2.channel < 8'(CHANNELS),
		"EN or DIS channel out of range")
	`TCLD_ASSERT_SAME(a_line_length_bound, 1'b1, len_q <= LEN_W'(MAX_LINE - 1),
		"line length beyond its limit")
	`TCLD_ASSERT_NEXT(a_line_end_clears, advance && is_eol(byte_s1),
		len_q == '0 && state_q.phase == PH_START,
		"parser not cleared after a line end")

endmodule
